// ----- rtl/pcd_pkg.sv -----
package pcd_pkg;

  // table and field sizes
  localparam int MAX_CODES    = 16;
  localparam int MAX_CODE_LEN = 16;
  localparam int IDX_W        = 4;
  localparam int CODE_W       = 16;
  localparam int LEN_W        = 5;
  localparam int SYM_W        = 8;
  localparam int CNT_W        = 16;
  localparam int USED_W       = 5;
  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = 16;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_ENTRIES_IN_USE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_LIMIT   = 1'b1;

  // request kinds as seen by the back end
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_BIT  = 1'b1
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_SYMBOL      = 2'd0,
    ST_TOO_LONG    = 2'd1,
    ST_AFTER_LIMIT = 2'd2
  } status_t;

  // classified command between front and back
  typedef struct packed {
    op_t                op;
    logic [IDX_W-1:0]   entry_index;
    logic [CODE_W-1:0]  entry_code;
    logic [LEN_W-1:0]   entry_len;
    logic [SYM_W-1:0]   entry_symbol;
    logic               bit_value;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    status_t          status;
    logic             last;
  } res_t;

  // mask with the low len bits set
  function automatic logic [CODE_W-1:0] len_mask(input logic [LEN_W-1:0] len);
    logic [CODE_W:0] m;
    m = ({{CODE_W{1'b0}}, 1'b1} << len) - {{CODE_W{1'b0}}, 1'b1};
    return m[CODE_W-1:0];
  endfunction

endpackage

// ----- rtl/pcd_front.sv -----
module pcd_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic                     req_type,
  input  logic [pcd_pkg::IDX_W-1:0]  entry_index,
  input  logic [pcd_pkg::CODE_W-1:0] entry_code,
  input  logic [pcd_pkg::LEN_W-1:0]  entry_len,
  input  logic [pcd_pkg::SYM_W-1:0]  entry_symbol,
  input  logic                     bit_value,
  output logic                     cmd_valid,
  output pcd_pkg::cmd_t            cmd,
  input  logic                     cmd_take
);

  // two-entry command queue
  pcd_pkg::cmd_t slot [2];
  logic          wptr;
  logic          rptr;
  logic [1:0]    count;
  logic          do_push;
  pcd_pkg::cmd_t incoming;

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = slot[rptr];
  assign do_push   = push && !full;

  // classify the incoming request
  always_comb begin
    incoming.op           = req_type ? pcd_pkg::OP_BIT : pcd_pkg::OP_LOAD;
    incoming.entry_index  = entry_index;
    incoming.entry_code   = entry_code;
    incoming.entry_len    = entry_len;
    incoming.entry_symbol = entry_symbol;
    incoming.bit_value    = bit_value;
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wptr] <= incoming;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= ~wptr;
      end
      if (cmd_take) begin
        rptr <= ~rptr;
      end
      if (do_push && !cmd_take) begin
        count <= count + 2'd1;
      end else if (!do_push && cmd_take) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ----- rtl/pcd_back.sv -----
module pcd_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [pcd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pcd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            cmd_valid,
  input  pcd_pkg::cmd_t                   cmd,
  output logic                            cmd_take,
  input  logic                            res_full,
  output logic                            res_push,
  output pcd_pkg::res_t                   res
);

  // code table, written by load commands only
  logic [pcd_pkg::CODE_W-1:0] tbl_code   [pcd_pkg::MAX_CODES];
  logic [pcd_pkg::LEN_W-1:0]  tbl_length [pcd_pkg::MAX_CODES];
  logic [pcd_pkg::SYM_W-1:0]  tbl_symbol [pcd_pkg::MAX_CODES];

  // configuration
  logic [pcd_pkg::USED_W-1:0] entries_in_use;
  logic [pcd_pkg::CNT_W-1:0]  output_limit;

  // decode state
  logic [pcd_pkg::CODE_W-1:0] acc;
  logic [pcd_pkg::LEN_W-1:0]  acc_len;
  logic [pcd_pkg::CNT_W-1:0]  symbol_count;
  logic                       finished;

  logic [pcd_pkg::CODE_W-1:0] acc_next;
  logic [pcd_pkg::LEN_W-1:0]  acc_len_next;
  logic [pcd_pkg::CNT_W-1:0]  symbol_count_next;
  logic                       finished_next;

  logic [pcd_pkg::CODE_W-1:0] acc_shift;
  logic [pcd_pkg::LEN_W-1:0]  len_inc;
  logic [pcd_pkg::CNT_W-1:0]  count_inc;
  logic [pcd_pkg::USED_W-1:0] used;
  logic                       hit;
  logic [pcd_pkg::SYM_W-1:0]  hit_sym;
  logic                       is_bit;

  assign cmd_take = cmd_valid && !res_full;
  assign is_bit   = (cmd.op == pcd_pkg::OP_BIT);

  // shifted accumulator and saturated entry count
  always_comb begin
    acc_shift = {acc[pcd_pkg::CODE_W-2:0], cmd.bit_value};
    len_inc   = acc_len + pcd_pkg::LEN_W'(1);
    count_inc = symbol_count + pcd_pkg::CNT_W'(1);
    if (entries_in_use > pcd_pkg::USED_W'(pcd_pkg::MAX_CODES)) begin
      used = pcd_pkg::USED_W'(pcd_pkg::MAX_CODES);
    end else begin
      used = entries_in_use;
    end
  end

  // parallel exact compare, highest matching slot wins
  always_comb begin
    hit     = 1'b0;
    hit_sym = '0;
    for (int k = 0; k < pcd_pkg::MAX_CODES; k++) begin
      if ((pcd_pkg::USED_W'(k) < used) &&
          (tbl_length[k] != '0) &&
          (tbl_length[k] <= pcd_pkg::LEN_W'(pcd_pkg::MAX_CODE_LEN)) &&
          (tbl_length[k] == len_inc) &&
          ((tbl_code[k] & pcd_pkg::len_mask(tbl_length[k])) == acc_shift)) begin
        hit     = 1'b1;
        hit_sym = tbl_symbol[k];
      end
    end
  end

  // next decode state and result
  always_comb begin
    acc_next          = acc;
    acc_len_next      = acc_len;
    symbol_count_next = symbol_count;
    finished_next     = finished;
    res_push          = 1'b0;
    res.symbol        = '0;
    res.status        = pcd_pkg::ST_SYMBOL;
    res.last          = 1'b0;
    if (cmd_take && is_bit) begin
      if (finished) begin
        res_push   = 1'b1;
        res.status = pcd_pkg::ST_AFTER_LIMIT;
      end else if (hit) begin
        acc_next          = '0;
        acc_len_next      = '0;
        symbol_count_next = count_inc;
        res_push          = 1'b1;
        res.symbol        = hit_sym;
        if (count_inc == output_limit) begin
          finished_next = 1'b1;
          res.last      = 1'b1;
        end
      end else if (len_inc >= pcd_pkg::LEN_W'(pcd_pkg::MAX_CODE_LEN)) begin
        acc_next     = '0;
        acc_len_next = '0;
        res_push     = 1'b1;
        res.status   = pcd_pkg::ST_TOO_LONG;
      end else begin
        acc_next     = acc_shift;
        acc_len_next = len_inc;
      end
    end
  end

  // table writes
  always_ff @(posedge clk) begin
    if (cmd_take && !is_bit) begin
      tbl_code[cmd.entry_index]   <= cmd.entry_code;
      tbl_length[cmd.entry_index] <= cmd.entry_len;
      tbl_symbol[cmd.entry_index] <= cmd.entry_symbol;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= '0;
      output_limit   <= '1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        pcd_pkg::REG_ENTRIES_IN_USE: entries_in_use <= cfg_data[pcd_pkg::USED_W-1:0];
        pcd_pkg::REG_OUTPUT_LIMIT:   output_limit   <= cfg_data[pcd_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // decode state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      acc          <= '0;
      acc_len      <= '0;
      symbol_count <= '0;
      finished     <= 1'b0;
    end else begin
      acc          <= acc_next;
      acc_len      <= acc_len_next;
      symbol_count <= symbol_count_next;
      finished     <= finished_next;
    end
  end

endmodule

// ----- rtl/pcd_result_queue.sv -----
module pcd_result_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        res_push,
  input  pcd_pkg::res_t               res,
  output logic                        res_full,
  output logic                        empty,
  input  logic                        pop,
  output logic [pcd_pkg::SYM_W-1:0]   symbol,
  output logic [1:0]                  status,
  output logic                        last
);

  // two-entry result queue
  pcd_pkg::res_t slot [2];
  logic          wptr;
  logic          rptr;
  logic [1:0]    count;
  logic          do_pop;
  pcd_pkg::res_t head;

  assign res_full = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign do_pop   = pop && !empty;
  assign head     = slot[rptr];
  assign symbol   = head.symbol;
  assign status   = head.status;
  assign last     = head.last;

  // queue storage
  always_ff @(posedge clk) begin
    if (res_push) begin
      slot[wptr] <= res;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (res_push) begin
        wptr <= ~wptr;
      end
      if (do_pop) begin
        rptr <= ~rptr;
      end
      if (res_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (!res_push && do_pop) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ----- rtl/prefix_code_bit_decoder.sv -----
// a result passes through the command queue and then the result queue before it can be popped
// throughput: one item per cycle, sustained while pop keeps up with results
// the rate is set by the combinational parallel compare of all table slots in the back end
// reset (rst, synchronous): empties both queues, clears accumulator, symbol count and finished,
// sets entries_in_use to 0 and output_limit to 65535; the code table is not cleared
module prefix_code_bit_decoder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [pcd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pcd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            push,
  output logic                            full,
  input  logic                            req_type,
  input  logic [pcd_pkg::IDX_W-1:0]       entry_index,
  input  logic [pcd_pkg::CODE_W-1:0]      entry_code,
  input  logic [pcd_pkg::LEN_W-1:0]       entry_len,
  input  logic [pcd_pkg::SYM_W-1:0]       entry_symbol,
  input  logic                            bit_value,
  output logic                            empty,
  input  logic                            pop,
  output logic [pcd_pkg::SYM_W-1:0]       symbol,
  output logic [1:0]                      status,
  output logic                            last
);

  logic          cmd_valid;
  logic          cmd_take;
  pcd_pkg::cmd_t cmd;
  logic          res_full;
  logic          res_push;
  pcd_pkg::res_t res;

  // request intake and classification
  pcd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .req_type     (req_type),
    .entry_index  (entry_index),
    .entry_code   (entry_code),
    .entry_len    (entry_len),
    .entry_symbol (entry_symbol),
    .bit_value    (bit_value),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_take     (cmd_take)
  );

  // table, accumulator and matching
  pcd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  // result buffering toward the consumer
  pcd_result_queue u_result_queue (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .symbol   (symbol),
    .status   (status),
    .last     (last)
  );

endmodule

// ----- tb/sv/prefix_code_bit_decoder_tb.sv -----
module prefix_code_bit_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STUCK_LIMIT = 1000;

  // block ports
  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_write = 1'b0;
  logic [pcd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [pcd_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                            push = 1'b0;
  logic                            full;
  logic                            req_type = 1'b0;
  logic [pcd_pkg::IDX_W-1:0]       entry_index = '0;
  logic [pcd_pkg::CODE_W-1:0]      entry_code = '0;
  logic [pcd_pkg::LEN_W-1:0]       entry_len = '0;
  logic [pcd_pkg::SYM_W-1:0]       entry_symbol = '0;
  logic                            bit_value = 1'b0;
  logic                            empty;
  logic                            pop = 1'b0;
  logic [pcd_pkg::SYM_W-1:0]       symbol;
  logic [1:0]                      status;
  logic                            last;

  // stimulus and expected results
  pcd_pkg::cmd_t stream_q[$];
  pcd_pkg::res_t decoded_q[$];
  pcd_pkg::cmd_t cur;
  bit            holding = 1'b0;
  bit            no_idling = 1'b0;
  int            gap_left = 0;
  int            stall_left = 0;
  int            queued = 0;
  int            mismatches = 0;
  int            result_no = 0;
  int            stuck_cycles = 0;
  pcd_pkg::res_t want;

  // decoder state as predicted
  logic [pcd_pkg::CODE_W-1:0] tbl_code [pcd_pkg::MAX_CODES];
  logic [pcd_pkg::LEN_W-1:0]  tbl_len [pcd_pkg::MAX_CODES];
  logic [pcd_pkg::SYM_W-1:0]  tbl_sym [pcd_pkg::MAX_CODES];
  logic [pcd_pkg::CODE_W-1:0] acc = '0;
  logic [pcd_pkg::LEN_W-1:0]  acc_len = '0;
  logic [pcd_pkg::CNT_W-1:0]  sym_count = '0;
  bit                         done = 1'b0;
  logic [pcd_pkg::USED_W-1:0] used_reg = '0;
  logic [pcd_pkg::CNT_W-1:0]  limit_reg = 16'hFFFF;

  // table contents as seen by the stream generator
  logic [pcd_pkg::CODE_W-1:0] gen_code [pcd_pkg::MAX_CODES];
  logic [pcd_pkg::LEN_W-1:0]  gen_len [pcd_pkg::MAX_CODES];

  prefix_code_bit_decoder DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (push),
    .full         (full),
    .req_type     (req_type),
    .entry_index  (entry_index),
    .entry_code   (entry_code),
    .entry_len    (entry_len),
    .entry_symbol (entry_symbol),
    .bit_value    (bit_value),
    .empty        (empty),
    .pop          (pop),
    .symbol       (symbol),
    .status       (status),
    .last         (last)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // advance the predicted decoder by one accepted item
  task automatic decode_item(input pcd_pkg::cmd_t it);
    pcd_pkg::res_t              r;
    bit                         hit;
    logic [pcd_pkg::SYM_W-1:0]  s;
    logic [pcd_pkg::CODE_W-1:0] m;
    logic [pcd_pkg::USED_W-1:0] n_used;
    if (it.op == pcd_pkg::OP_LOAD) begin
      tbl_code[it.entry_index] = it.entry_code;
      tbl_len[it.entry_index] = it.entry_len;
      tbl_sym[it.entry_index] = it.entry_symbol;
    end else begin
      r.symbol = '0;
      r.status = pcd_pkg::ST_SYMBOL;
      r.last = 1'b0;
      if (done) begin
        r.status = pcd_pkg::ST_AFTER_LIMIT;
        decoded_q.push_back(r);
      end else begin
        acc = {acc[pcd_pkg::CODE_W-2:0], it.bit_value};
        acc_len = acc_len + 5'd1;
        n_used = (used_reg > 5'd16) ? 5'd16 : used_reg;
        hit = 1'b0;
        s = '0;
        // exact compare against every slot in use, highest slot wins
        for (int k = 0; k < int'(n_used); k++) begin
          if (tbl_len[k] != 5'd0 && tbl_len[k] <= 5'd16 && tbl_len[k] == acc_len) begin
            m = 16'hFFFF >> (5'd16 - tbl_len[k]);
            if ((tbl_code[k] & m) == acc) begin
              hit = 1'b1;
              s = tbl_sym[k];
            end
          end
        end
        if (hit) begin
          acc = '0;
          acc_len = '0;
          sym_count = sym_count + 16'd1;
          r.symbol = s;
          if (sym_count == limit_reg) begin
            done = 1'b1;
            r.last = 1'b1;
          end
          decoded_q.push_back(r);
        end else if (acc_len >= 5'd16) begin
          // no code matched at full length
          acc = '0;
          acc_len = '0;
          r.status = pcd_pkg::ST_TOO_LONG;
          decoded_q.push_back(r);
        end
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] exp_val);
    $display("result %0d: %s got %0h want %0h", result_no, what, got, exp_val);
    mismatches++;
  endtask

  // stimulus queue helpers
  task automatic add_load(input logic [pcd_pkg::IDX_W-1:0] idx,
                          input logic [pcd_pkg::CODE_W-1:0] code,
                          input logic [pcd_pkg::LEN_W-1:0] len,
                          input logic [pcd_pkg::SYM_W-1:0] sym);
    pcd_pkg::cmd_t it;
    it.op = pcd_pkg::OP_LOAD;
    it.entry_index = idx;
    it.entry_code = code;
    it.entry_len = len;
    it.entry_symbol = sym;
    it.bit_value = 1'($urandom);
    gen_code[idx] = code;
    gen_len[idx] = len;
    stream_q.push_back(it);
    queued++;
  endtask

  task automatic add_bit(input logic b);
    pcd_pkg::cmd_t it;
    it.op = pcd_pkg::OP_BIT;
    it.entry_index = pcd_pkg::IDX_W'($urandom);
    it.entry_code = pcd_pkg::CODE_W'($urandom);
    it.entry_len = pcd_pkg::LEN_W'($urandom);
    it.entry_symbol = pcd_pkg::SYM_W'($urandom);
    it.bit_value = b;
    stream_q.push_back(it);
    queued++;
  endtask

  // bits of one code, first bit first; a partial count gives a broken code
  task automatic add_code(input int k, input int nbits);
    int len;
    len = int'(gen_len[k]);
    for (int b = len - 1; b >= len - nbits; b--) add_bit(gen_code[k][b]);
  endtask

  // write one register while the block is idle
  task automatic write_reg(input logic [pcd_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [15:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    cfg_data <= pcd_pkg::CFG_DATA_W'($urandom);
    unique case (idx)
      pcd_pkg::REG_ENTRIES_IN_USE: used_reg = val[pcd_pkg::USED_W-1:0];
      pcd_pkg::REG_OUTPUT_LIMIT:   limit_reg = val;
      default: ;
    endcase
  endtask

  // wait until every item is in and every result is out
  task automatic drain();
    while (stream_q.size() != 0 || holding || decoded_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // canonical prefix-free table, sometimes with a duplicate or a dead slot
  task automatic load_prefix_table();
    logic [pcd_pkg::CODE_W-1:0] t_code [pcd_pkg::MAX_CODES];
    int                         t_len [pcd_pkg::MAX_CODES];
    int                         slot [pcd_pkg::MAX_CODES];
    logic [pcd_pkg::CODE_W-1:0] c;
    logic [pcd_pkg::CODE_W-1:0] m;
    int                         cap, ln, prev, a, b, tmp;
    cap = 65536;
    prev = $urandom_range(1, 3);
    c = '0;
    for (int j = 0; j < pcd_pkg::MAX_CODES; j++) begin
      ln = prev + $urandom_range(0, 2);
      if (ln > 16) ln = 16;
      while ((1 << (16 - ln)) > cap - (15 - j)) ln++;
      if (j > 0) c = (c + 16'd1) << (ln - prev);
      cap = cap - (1 << (16 - ln));
      prev = ln;
      t_code[j] = c;
      t_len[j] = ln;
      slot[j] = j;
    end
    // shuffle which slot holds which code
    for (int j = pcd_pkg::MAX_CODES - 1; j > 0; j--) begin
      a = $urandom_range(0, j);
      tmp = slot[j];
      slot[j] = slot[a];
      slot[a] = tmp;
    end
    for (int j = 0; j < pcd_pkg::MAX_CODES; j++) begin
      ln = t_len[j];
      m = 16'hFFFF >> (16 - ln);
      c = t_code[j];
      if ($urandom_range(0, 1) == 1) c = c | (pcd_pkg::CODE_W'($urandom) & ~m);
      add_load(pcd_pkg::IDX_W'(slot[j]), c, pcd_pkg::LEN_W'(ln),
               pcd_pkg::SYM_W'($urandom));
    end
    // duplicate code in a higher slot
    if ($urandom_range(0, 2) == 0) begin
      a = $urandom_range(0, pcd_pkg::MAX_CODES - 2);
      b = $urandom_range(a + 1, pcd_pkg::MAX_CODES - 1);
      add_load(pcd_pkg::IDX_W'(b), gen_code[a], gen_len[a], pcd_pkg::SYM_W'($urandom));
    end
    // slot with a length that never matches
    if ($urandom_range(0, 3) == 0) begin
      a = $urandom_range(0, pcd_pkg::MAX_CODES - 1);
      ln = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(17, 31);
      add_load(pcd_pkg::IDX_W'(a), pcd_pkg::CODE_W'($urandom), pcd_pkg::LEN_W'(ln),
               pcd_pkg::SYM_W'($urandom));
    end
  endtask

  // one phase of mostly well-formed code sequences with random content
  task automatic stream_phase(input int n);
    int start, r, k, n_used, len;
    start = queued;
    load_prefix_table();
    while (queued - start < n) begin
      n_used = (used_reg > 5'd16) ? 16 : int'(used_reg);
      r = $urandom_range(0, 99);
      if (r < 80 && n_used > 0) begin
        k = $urandom_range(0, n_used - 1);
        len = int'(gen_len[k]);
        if (len >= 1 && len <= 16) add_code(k, len);
        else add_bit(1'($urandom));
      end else if (r < 92) begin
        repeat ($urandom_range(1, 20)) add_bit(1'($urandom));
      end else if (r < 96 && n_used > 0) begin
        k = $urandom_range(0, n_used - 1);
        len = int'(gen_len[k]);
        if (len >= 2 && len <= 16) add_code(k, $urandom_range(1, len - 1));
        else add_bit(1'($urandom));
      end else begin
        add_load(pcd_pkg::IDX_W'($urandom), pcd_pkg::CODE_W'($urandom),
                 pcd_pkg::LEN_W'($urandom_range(0, 31)), pcd_pkg::SYM_W'($urandom));
      end
    end
  endtask

  // driver: one transfer per accepted item, random gaps between items
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        decode_item(cur);
        holding = 1'b0;
      end
      if (!holding) begin
        if (!no_idling && gap_left == 0 && stream_q.size() > 0 && $urandom_range(0, 15) == 0)
          gap_left = $urandom_range(1, 18);
        if ((!no_idling && gap_left > 0) || stream_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          push <= 1'b0;
        end else begin
          cur = stream_q.pop_front();
          holding = 1'b1;
          push <= 1'b1;
          req_type <= cur.op;
          entry_index <= cur.entry_index;
          entry_code <= cur.entry_code;
          entry_len <= cur.entry_len;
          entry_symbol <= cur.entry_symbol;
          bit_value <= cur.bit_value;
        end
      end
    end
  end

  // monitor: check each result transfer against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        result_no++;
        if (decoded_q.size() == 0) begin
          report_mismatch("unexpected result, status", {14'd0, status}, 16'd0);
        end else begin
          want = decoded_q.pop_front();
          if (symbol !== want.symbol) report_mismatch("symbol", {8'd0, symbol}, {8'd0, want.symbol});
          if (status !== want.status) report_mismatch("status", {14'd0, status}, {14'd0, want.status});
          if (last !== want.last) report_mismatch("last", {15'd0, last}, {15'd0, want.last});
        end
      end
      if (!no_idling && stall_left == 0 && $urandom_range(0, 11) == 0)
        stall_left = $urandom_range(1, 18);
      if (!no_idling && stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // cycles without any transfer or register write
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || cfg_write) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
  end

  // watchdog
  initial begin
    while (stuck_cycles < STUCK_LIMIT) @(posedge clk);
    $display("prefix_code_bit_decoder: mismatch");
    $finish;
  end

  // test sequence
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: short codes, duplicate, dead lengths, longest code
    write_reg(pcd_pkg::REG_ENTRIES_IN_USE, 16'd8);
    add_load(4'd0, 16'h0000, 5'd1, 8'h00);
    add_load(4'd1, 16'hFFFE, 5'd2, 8'h11);
    add_load(4'd2, 16'h0006, 5'd0, 8'h22);
    add_load(4'd3, 16'h0006, 5'd3, 8'h33);
    add_load(4'd4, 16'h0000, 5'd31, 8'h44);
    add_load(4'd5, 16'h0002, 5'd2, 8'hA5);
    add_load(4'd6, 16'hFFFF, 5'd16, 8'hFF);
    add_load(4'd7, 16'hFFFF, 5'd17, 8'h77);
    add_code(0, 1);
    add_code(5, 2);
    add_code(3, 3);
    add_code(6, 16);
    drain();

    // random phases over a spread of settings
    write_reg(pcd_pkg::REG_ENTRIES_IN_USE, 16'd16);
    write_reg(pcd_pkg::REG_OUTPUT_LIMIT, 16'd1);
    stream_phase(200);
    drain();
    write_reg(pcd_pkg::REG_ENTRIES_IN_USE, 16'd31);
    write_reg(pcd_pkg::REG_OUTPUT_LIMIT, 16'd0);
    stream_phase(200);
    drain();
    write_reg(pcd_pkg::REG_ENTRIES_IN_USE, 16'd0);
    write_reg(pcd_pkg::REG_OUTPUT_LIMIT, 16'hFFFF);
    stream_phase(200);
    drain();
    write_reg(pcd_pkg::REG_ENTRIES_IN_USE, 16'd1);
    stream_phase(200);
    drain();
    write_reg(pcd_pkg::REG_ENTRIES_IN_USE, 16'($urandom_range(2, 15)));
    write_reg(pcd_pkg::REG_OUTPUT_LIMIT, 16'($urandom_range(int'(sym_count) + 3000, 65535)));
    stream_phase(200);
    drain();
    write_reg(pcd_pkg::REG_ENTRIES_IN_USE, 16'($urandom_range(17, 30)));
    stream_phase(200);
    drain();
    write_reg(pcd_pkg::REG_ENTRIES_IN_USE, 16'd16);
    if (sym_count > 16'd2)
      write_reg(pcd_pkg::REG_OUTPUT_LIMIT, 16'($urandom_range(2, int'(sym_count) - 1)));
    stream_phase(200);
    drain();
    write_reg(pcd_pkg::REG_ENTRIES_IN_USE, 16'($urandom_range(1, 16)));
    stream_phase(200);
    drain();

    // last part: no idling, reach the output limit, then input after it
    no_idling = 1'b1;
    write_reg(pcd_pkg::REG_ENTRIES_IN_USE, 16'd16);
    write_reg(pcd_pkg::REG_OUTPUT_LIMIT, sym_count + 16'd5);
    stream_phase(200);
    add_load(4'd15, 16'h1234, 5'd16, 8'h5A);
    add_bit(1'b1);
    add_bit(1'b0);
    drain();

    if (mismatches == 0) begin
      $display("prefix_code_bit_decoder: match");
    end else begin
      $display("prefix_code_bit_decoder: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/pcd_pkg.sv
rtl/pcd_front.sv
rtl/pcd_back.sv
rtl/pcd_result_queue.sv
rtl/prefix_code_bit_decoder.sv
tb/sv/prefix_code_bit_decoder_tb.sv
